/* src/sih_pkg.sv */
// sih_pkg: shared types, codes, constants and the FNV-1a step for the
// string intern hash table. No dependencies.
`default_nettype none
package sih_pkg;

  localparam int DEF_TABLE_SLOTS = 1024;
  localparam int DEF_POOL_BYTES  = 16384;
  localparam int DEF_MAX_KEY_LEN = 64;

  localparam int IDW      = 10;
  localparam int LIMW     = 11;
  localparam int LIMIT_RESET = 768;

  localparam logic [63:0] FNV_BASIS = 64'd14695981039346656037;

  localparam logic [1:0] CMD_INTERN   = 2'd0;
  localparam logic [1:0] CMD_CONTAINS = 2'd1;
  localparam logic [1:0] CMD_TEXT     = 2'd2;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_BAD_ID   = 2'd1;
  localparam logic [1:0] STAT_FULL     = 2'd2;
  localparam logic [1:0] STAT_TOO_LONG = 2'd3;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_SLOT_RD, S_SLOT_CHK, S_ENT_CHK, S_CMP_RD, S_CMP_CHK,
    S_DECIDE, S_COPY_RD, S_COPY_WR, S_COMMIT, S_RESULT, S_TXT_CHK, S_TXT_RD,
    S_TXT_EMIT
  } state_t;

  typedef enum logic [1:0] {PR_EMPTY, PR_MATCH, PR_EXHAUST} probe_t;

  // prime = 2^40 + 0x1B3
  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage
`default_nettype wire

/* src/string_intern_hash_table_core.sv */
// Key bytes: one transaction per cycle, no result until the last item.
// End of key: slot read and check, an entry check per occupied slot, a byte
// compare on equal length, decide, on insert byte copy and commit, then result;
// text: a check, then a read and emit per byte. One item in flight at a time.
// Reset: synchronous; a clearing pass over every table slot keeps in_ready low.
`default_nettype none
module string_intern_hash_table_core #(
  parameter int TABLE_SLOTS = sih_pkg::DEF_TABLE_SLOTS,
  parameter int POOL_BYTES  = sih_pkg::DEF_POOL_BYTES,
  parameter int MAX_KEY_LEN = sih_pkg::DEF_MAX_KEY_LEN
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  cmd,
  input  wire logic [7:0]  key_byte,
  input  wire logic        byte_present,
  input  wire logic        key_last,
  input  wire logic [9:0]  lookup_id,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [9:0]       symbol_id,
  output logic             found,
  output logic [1:0]       status,
  output logic [7:0]       text_byte,
  output logic             text_valid,
  output logic             result_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [10:0] cfg_data
);
  localparam int SW  = $clog2(TABLE_SLOTS);
  localparam int PW  = $clog2(POOL_BYTES);
  localparam int PFW = $clog2(POOL_BYTES + 1);
  localparam int KLW = $clog2(MAX_KEY_LEN + 2);
  localparam int KBW = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
  localparam int IDW = sih_pkg::IDW;
  localparam int CW  = IDW + 1;
  localparam int EW  = PFW + KLW;

  sih_pkg::state_t state, state_next;
  sih_pkg::probe_t probe_r;

  logic [1:0]     cur_cmd;
  logic [KLW-1:0] cur_len, pos;
  logic [PFW-1:0] cur_off, pool_fill;
  logic [IDW-1:0] cur_id, res_id;
  logic           res_found;
  logic [1:0]     res_status;
  logic [SW-1:0]  idx, clr;
  logic [SW:0]    step;
  logic [CW-1:0]  sym_count;
  logic [sih_pkg::LIMW-1:0] load_limit;

  logic           in_acc, key_step, out_free, out_load;
  logic [63:0]    upd_hash;
  logic [KLW-1:0] upd_len, ent_len, ent_off_len, txt_len, pos_inc;
  logic [PFW-1:0] ent_off;
  logic [SW:0]    step_inc;
  logic           probe_last, pos_end, full, mismatch;

  logic           slot_we, slot_re;
  logic [SW-1:0]  slot_waddr;
  logic [CW-1:0]  slot_wdata, slot_rdata;
  logic           ent_we, ent_re;
  logic [IDW-1:0] ent_raddr;
  logic [EW-1:0]  ent_wdata, ent_rdata;
  logic           pool_we, pool_re;
  logic [PW-1:0]  pool_waddr, pool_raddr;
  logic [7:0]     pool_rdata, kb_rdata;
  logic           kb_re;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == sih_pkg::S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign key_step  = in_acc && (cmd == sih_pkg::CMD_INTERN || cmd == sih_pkg::CMD_CONTAINS);
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    ent_len     = ent_rdata[KLW-1:0];
    ent_off     = ent_rdata[EW-1:KLW];
    ent_off_len = ent_len;
    txt_len     = (ent_len > KLW'(MAX_KEY_LEN)) ? KLW'(MAX_KEY_LEN) : ent_off_len;
    step_inc    = step + 1'b1;
    probe_last  = (step_inc == (SW+1)'(TABLE_SLOTS));
    pos_inc     = pos + 1'b1;
    pos_end     = (pos_inc == cur_len);
    mismatch    = (pool_rdata != kb_rdata);
    full        = (sym_count >= load_limit) || sym_count[IDW] ||
                  (({1'b0, pool_fill} + (PFW+1)'(cur_len)) > (PFW+1)'(POOL_BYTES));
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sih_pkg::S_CLEAR: if (clr == SW'(TABLE_SLOTS - 1)) state_next = sih_pkg::S_IDLE;
      sih_pkg::S_IDLE: begin
        if (in_acc) begin
          if (cmd == sih_pkg::CMD_TEXT) begin
            state_next = ({1'b0, lookup_id} >= sym_count) ? sih_pkg::S_RESULT
                                                          : sih_pkg::S_TXT_CHK;
          end else if (key_step && key_last) begin
            state_next = (upd_len > KLW'(MAX_KEY_LEN)) ? sih_pkg::S_RESULT
                                                       : sih_pkg::S_SLOT_RD;
          end
        end
      end
      sih_pkg::S_SLOT_RD: state_next = sih_pkg::S_SLOT_CHK;
      sih_pkg::S_SLOT_CHK: begin
        state_next = (slot_rdata == '0) ? sih_pkg::S_DECIDE : sih_pkg::S_ENT_CHK;
      end
      sih_pkg::S_ENT_CHK: begin
        if (ent_len != cur_len) begin
          state_next = probe_last ? sih_pkg::S_DECIDE : sih_pkg::S_SLOT_RD;
        end else begin
          state_next = (cur_len == '0) ? sih_pkg::S_DECIDE : sih_pkg::S_CMP_RD;
        end
      end
      sih_pkg::S_CMP_RD: state_next = sih_pkg::S_CMP_CHK;
      sih_pkg::S_CMP_CHK: begin
        if (mismatch) begin
          state_next = probe_last ? sih_pkg::S_DECIDE : sih_pkg::S_SLOT_RD;
        end else begin
          state_next = pos_end ? sih_pkg::S_DECIDE : sih_pkg::S_CMP_RD;
        end
      end
      sih_pkg::S_DECIDE: begin
        if (cur_cmd == sih_pkg::CMD_CONTAINS || probe_r == sih_pkg::PR_MATCH ||
            probe_r == sih_pkg::PR_EXHAUST || full) begin
          state_next = sih_pkg::S_RESULT;
        end else begin
          state_next = (cur_len == '0) ? sih_pkg::S_COMMIT : sih_pkg::S_COPY_RD;
        end
      end
      sih_pkg::S_COPY_RD: state_next = sih_pkg::S_COPY_WR;
      sih_pkg::S_COPY_WR: state_next = pos_end ? sih_pkg::S_COMMIT : sih_pkg::S_COPY_RD;
      sih_pkg::S_COMMIT: state_next = sih_pkg::S_RESULT;
      sih_pkg::S_RESULT: if (out_free) state_next = sih_pkg::S_IDLE;
      sih_pkg::S_TXT_CHK: begin
        state_next = (txt_len == '0) ? sih_pkg::S_RESULT : sih_pkg::S_TXT_RD;
      end
      sih_pkg::S_TXT_RD: state_next = sih_pkg::S_TXT_EMIT;
      sih_pkg::S_TXT_EMIT: begin
        if (out_free) state_next = pos_end ? sih_pkg::S_IDLE : sih_pkg::S_TXT_RD;
      end
      default: state_next = sih_pkg::S_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    slot_re    = (state == sih_pkg::S_SLOT_RD);
    slot_we    = (state == sih_pkg::S_CLEAR) || (state == sih_pkg::S_COMMIT);
    slot_waddr = (state == sih_pkg::S_CLEAR) ? clr : idx;
    slot_wdata = (state == sih_pkg::S_CLEAR) ? '0 : CW'(sym_count + 1'b1);
    ent_re     = (in_acc && cmd == sih_pkg::CMD_TEXT) || (state == sih_pkg::S_SLOT_CHK);
    ent_raddr  = (state == sih_pkg::S_IDLE) ? lookup_id : IDW'(slot_rdata - 1'b1);
    ent_we     = (state == sih_pkg::S_COMMIT);
    ent_wdata  = {pool_fill, cur_len};
    pool_re    = (state == sih_pkg::S_CMP_RD) || (state == sih_pkg::S_TXT_RD);
    pool_raddr = PW'(cur_off + PFW'(pos));
    pool_we    = (state == sih_pkg::S_COPY_WR);
    pool_waddr = PW'(pool_fill + PFW'(pos));
    kb_re      = (state == sih_pkg::S_CMP_RD) || (state == sih_pkg::S_COPY_RD);
    out_load   = out_free && ((state == sih_pkg::S_RESULT) || (state == sih_pkg::S_TXT_EMIT));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= sih_pkg::S_CLEAR;
      clr        <= '0;
      sym_count  <= '0;
      pool_fill  <= '0;
      load_limit <= sih_pkg::LIMW'(sih_pkg::LIMIT_RESET);
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == sih_pkg::S_CLEAR) clr <= clr + 1'b1;
      if (cfg_valid) load_limit <= cfg_data;
      if (state == sih_pkg::S_COMMIT) begin
        sym_count <= sym_count + 1'b1;
        pool_fill <= pool_fill + PFW'(cur_len);
      end
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      sih_pkg::S_IDLE: begin
        if (in_acc && cmd == sih_pkg::CMD_TEXT) begin
          cur_id     <= lookup_id;
          res_id     <= lookup_id;
          res_found  <= 1'b0;
          res_status <= sih_pkg::STAT_BAD_ID;
        end else if (key_step && key_last) begin
          cur_cmd    <= cmd;
          cur_len    <= upd_len;
          idx        <= upd_hash[SW-1:0];
          step       <= '0;
          res_id     <= '0;
          res_found  <= 1'b0;
          res_status <= sih_pkg::STAT_TOO_LONG;
        end
      end
      sih_pkg::S_SLOT_CHK: begin
        if (slot_rdata == '0) probe_r <= sih_pkg::PR_EMPTY;
        else cur_id <= IDW'(slot_rdata - 1'b1);
      end
      sih_pkg::S_ENT_CHK: begin
        if (ent_len != cur_len) begin
          if (probe_last) probe_r <= sih_pkg::PR_EXHAUST;
          idx  <= idx + step_inc[SW-1:0];
          step <= step_inc;
        end else if (cur_len == '0) begin
          probe_r <= sih_pkg::PR_MATCH;
        end else begin
          cur_off <= ent_off;
          pos     <= '0;
        end
      end
      sih_pkg::S_CMP_CHK: begin
        if (mismatch) begin
          if (probe_last) probe_r <= sih_pkg::PR_EXHAUST;
          idx  <= idx + step_inc[SW-1:0];
          step <= step_inc;
        end else if (pos_end) begin
          probe_r <= sih_pkg::PR_MATCH;
        end else begin
          pos <= pos_inc;
        end
      end
      sih_pkg::S_DECIDE: begin
        pos        <= '0;
        res_id     <= '0;
        res_found  <= 1'b0;
        res_status <= sih_pkg::STAT_OK;
        if (cur_cmd == sih_pkg::CMD_CONTAINS) begin
          res_found <= (probe_r == sih_pkg::PR_MATCH);
        end else if (probe_r == sih_pkg::PR_MATCH) begin
          res_id    <= cur_id;
          res_found <= 1'b1;
        end else if (full || probe_r == sih_pkg::PR_EXHAUST) begin
          res_status <= sih_pkg::STAT_FULL;
        end
      end
      sih_pkg::S_COPY_WR: pos <= pos_inc;
      sih_pkg::S_COMMIT: begin
        res_id     <= sym_count[IDW-1:0];
        res_found  <= 1'b0;
        res_status <= sih_pkg::STAT_OK;
      end
      sih_pkg::S_TXT_CHK: begin
        res_status <= sih_pkg::STAT_OK;
        cur_off    <= ent_off;
        cur_len    <= txt_len;
        pos        <= '0;
      end
      sih_pkg::S_TXT_EMIT: if (out_free) pos <= pos_inc;
      default: ;
    endcase
    if (out_load) begin
      if (state == sih_pkg::S_RESULT) begin
        symbol_id   <= res_id;
        found       <= res_found;
        status      <= res_status;
        text_byte   <= '0;
        text_valid  <= 1'b0;
        result_last <= 1'b1;
      end else begin
        symbol_id   <= cur_id;
        found       <= 1'b0;
        status      <= sih_pkg::STAT_OK;
        text_byte   <= pool_rdata;
        text_valid  <= 1'b1;
        result_last <= pos_end;
      end
    end
  end

  sih_key #(.MAX_KEY_LEN(MAX_KEY_LEN)) u_key (
    .clk(clk), .rst(rst), .step(key_step), .key_byte(key_byte),
    .byte_present(byte_present), .key_last(key_last), .upd_hash(upd_hash),
    .upd_len(upd_len), .rd_en(kb_re), .rd_addr(pos[KBW-1:0]), .rd_data(kb_rdata)
  );

  sih_ram #(.DEPTH(TABLE_SLOTS), .WIDTH(CW)) u_slots (
    .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .re(slot_re), .raddr(idx), .rdata(slot_rdata)
  );

  sih_ram #(.DEPTH(1 << IDW), .WIDTH(EW)) u_entries (
    .clk(clk), .we(ent_we), .waddr(sym_count[IDW-1:0]), .wdata(ent_wdata),
    .re(ent_re), .raddr(ent_raddr), .rdata(ent_rdata)
  );

  sih_ram #(.DEPTH(POOL_BYTES), .WIDTH(8)) u_pool (
    .clk(clk), .we(pool_we), .waddr(pool_waddr), .wdata(kb_rdata),
    .re(pool_re), .raddr(pool_raddr), .rdata(pool_rdata)
  );
endmodule
`default_nettype wire

/* src/sih_ram.sv */
// sih_ram: simple dual-port synchronous RAM, registered read data.
// One write and one read port. No dependencies.
`default_nettype none
module sih_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

/* src/sih_key.sv */
// sih_key: running FNV-1a hash, key length and key byte buffer.
// Depends on sih_pkg and sih_ram.
`default_nettype none
module sih_key #(
  parameter int MAX_KEY_LEN = sih_pkg::DEF_MAX_KEY_LEN,
  localparam int KLW = $clog2(MAX_KEY_LEN + 2),
  localparam int KBW = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           step,
  input  wire logic [7:0]     key_byte,
  input  wire logic           byte_present,
  input  wire logic           key_last,
  output logic      [63:0]    upd_hash,
  output logic      [KLW-1:0] upd_len,
  input  wire logic           rd_en,
  input  wire logic [KBW-1:0] rd_addr,
  output logic      [7:0]     rd_data
);
  logic [63:0]    hash;
  logic [KLW-1:0] len;
  logic           buf_we;

  always_comb begin
    upd_hash = byte_present ? sih_pkg::fnv_step(hash, key_byte) : hash;
    upd_len  = (byte_present && len <= KLW'(MAX_KEY_LEN)) ? len + 1'b1 : len;
    buf_we   = step && byte_present && (len < KLW'(MAX_KEY_LEN));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash <= sih_pkg::FNV_BASIS;
      len  <= '0;
    end else if (step) begin
      hash <= key_last ? sih_pkg::FNV_BASIS : upd_hash;
      len  <= key_last ? '0 : upd_len;
    end
  end

  sih_ram #(.DEPTH(MAX_KEY_LEN), .WIDTH(8)) u_buf (
    .clk(clk), .we(buf_we), .waddr(len[KBW-1:0]), .wdata(key_byte),
    .re(rd_en), .raddr(rd_addr), .rdata(rd_data)
  );
endmodule
`default_nettype wire

/* src/sih_checker.sv */
// sih_checker: port-level assertions for string_intern_hash_table_core,
// bound to the top level. Depends on sih_pkg.
`default_nettype none
module sih_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [9:0] symbol_id,
  input wire logic       found,
  input wire logic [1:0] status,
  input wire logic       text_valid,
  input wire logic       result_last
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(symbol_id) && $stable(status))
    else $error("output transaction changed while stalled");

  a_clear: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("input taken during clearing pass");

  a_err_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != sih_pkg::STAT_OK |-> result_last && !text_valid && !found)
    else $error("error result not a single final transaction");

  a_text_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && text_valid |-> !found && status == sih_pkg::STAT_OK)
    else $error("text byte with found or error");
endmodule

bind string_intern_hash_table_core sih_checker u_sih_checker (.*);
`default_nettype wire

/* verif/tb_string_intern_hash_table_core.sv */
// Self-checking testbench for string_intern_hash_table_core: intern, contains and text
// transactions are checked against an in-bench model of the symbol table.
// Depends on src/sih_pkg.sv and src/string_intern_hash_table_core.sv.
`default_nettype none
module tb_string_intern_hash_table_core;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] kb;
    logic       pres;
    logic       last;
    logic [9:0] lid;
  } item_t;

  typedef struct packed {
    logic [9:0] id;
    logic       fnd;
    logic [1:0] st;
    logic [7:0] tb;
    logic       tv;
    logic       rl;
  } res_t;

  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam int SLOTS = 1024;
  localparam int POOL = 16384;
  localparam int MAXK = 64;
  localparam logic [63:0] HASH_MULT = 64'd1099511628211;
  localparam int CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] cmd = 2'd0;
  logic [7:0] key_byte = 8'd0;
  logic byte_present = 1'b0;
  logic key_last = 1'b0;
  logic [9:0] lookup_id = 10'd0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [9:0] symbol_id;
  logic found;
  logic [1:0] status;
  logic [7:0] text_byte;
  logic text_valid;
  logic result_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [10:0] cfg_data = 11'd0;

  string_intern_hash_table_core u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .key_byte(key_byte), .byte_present(byte_present),
    .key_last(key_last), .lookup_id(lookup_id),
    .out_valid(out_valid), .out_ready(out_ready),
    .symbol_id(symbol_id), .found(found), .status(status),
    .text_byte(text_byte), .text_valid(text_valid), .result_last(result_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // symbol table model
  logic [10:0] limit_m;
  logic [7:0]  kbuf [MAXK];
  int          klen;
  logic [63:0] khash;
  logic [10:0] slot_tab [SLOTS];
  int          ent_off [SLOTS];
  int          ent_len [SLOTS];
  logic [7:0]  pool_m [POOL];
  int          sym_cnt;
  int          pool_fill;

  item_t pend_items[$];
  res_t  exp_results[$];
  int    errs = 0;
  int    n_in = 0;
  int    n_out = 0;
  int    cyc = 0;
  bit    hold_req = 0;

  function automatic void queue_item(input item_t it);
    pend_items = {pend_items, it};
  endfunction

  function automatic void queue_result(input res_t r);
    exp_results = {exp_results, r};
  endfunction

  function automatic bit key_equal(input int id);
    if (ent_len[id] != klen) return 0;
    for (int i = 0; i < klen; i++)
      if (pool_m[ent_off[id] + i] != kbuf[i]) return 0;
    return 1;
  endfunction

  task automatic model_item(input item_t it);
    res_t r;
    int idx, slot, outcome, e, len;
    r = '0;
    r.rl = 1'b1;
    if (it.cmd == CMD_NOP) return;
    if (it.cmd == sih_pkg::CMD_TEXT) begin
      r.id = it.lid;
      if (int'(it.lid) >= sym_cnt) begin
        r.st = sih_pkg::STAT_BAD_ID;
        queue_result(r);
      end else if (ent_len[it.lid] == 0) begin
        queue_result(r);
      end else begin
        len = ent_len[it.lid];
        for (int i = 0; i < len; i++) begin
          r.tb = pool_m[ent_off[it.lid] + i];
          r.tv = 1'b1;
          r.rl = (i == len - 1);
          queue_result(r);
        end
      end
      return;
    end
    if (it.pres) begin
      khash = (khash ^ {56'd0, it.kb}) * HASH_MULT;
      if (klen < MAXK) kbuf[klen] = it.kb;
      if (klen <= MAXK) klen++;
    end
    if (!it.last) return;
    if (klen > MAXK) begin
      r.st = sih_pkg::STAT_TOO_LONG;
    end else begin
      idx = int'(khash[9:0]);
      outcome = 2;
      slot = 0;
      for (int s = 0; s < SLOTS; s++) begin
        e = int'(slot_tab[idx]);
        if (e == 0) begin
          outcome = 0; slot = idx; break;
        end
        if (key_equal(e - 1)) begin
          outcome = 1; slot = idx; break;
        end
        idx = (idx + s + 1) & (SLOTS - 1);
      end
      if (it.cmd == sih_pkg::CMD_CONTAINS) begin
        r.fnd = (outcome == 1);
      end else if (outcome == 1) begin
        r.id = 10'(int'(slot_tab[slot]) - 1);
        r.fnd = 1'b1;
      end else if (outcome == 2 || sym_cnt >= int'(limit_m) || sym_cnt >= SLOTS ||
                   klen > POOL - pool_fill) begin
        r.st = sih_pkg::STAT_FULL;
      end else begin
        for (int i = 0; i < klen; i++) pool_m[pool_fill + i] = kbuf[i];
        ent_off[sym_cnt] = pool_fill;
        ent_len[sym_cnt] = klen;
        pool_fill += klen;
        slot_tab[slot] = 11'(sym_cnt + 1);
        r.id = 10'(sym_cnt);
        sym_cnt++;
      end
    end
    queue_result(r);
    klen = 0;
    khash = sih_pkg::FNV_BASIS;
  endtask

  // checker and model update; check before predicting on the same edge
  always @(posedge clk) begin : mon
    res_t a, x;
    if (rst) begin
      limit_m <= 11'(sih_pkg::LIMIT_RESET);
      klen = 0;
      khash = sih_pkg::FNV_BASIS;
      sym_cnt = 0;
      pool_fill = 0;
      for (int i = 0; i < SLOTS; i++) slot_tab[i] = 11'd0;
    end else begin
      if (cfg_valid && cfg_ready) limit_m <= cfg_data;
      if (out_valid && out_ready) begin
        a = '{symbol_id, found, status, text_byte, text_valid, result_last};
        n_out++;
        if (exp_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, a);
          errs++;
        end else begin
          x = exp_results.pop_front();
          if (x.id != a.id) begin
            $display("%0t: symbol_id expected %0d actual %0d", $time, x.id, a.id); errs++;
          end
          if (x.fnd != a.fnd) begin
            $display("%0t: found expected %0d actual %0d", $time, x.fnd, a.fnd); errs++;
          end
          if (x.st != a.st) begin
            $display("%0t: status expected %0d actual %0d", $time, x.st, a.st); errs++;
          end
          if (x.tb != a.tb) begin
            $display("%0t: text_byte expected %h actual %h", $time, x.tb, a.tb); errs++;
          end
          if (x.tv != a.tv) begin
            $display("%0t: text_valid expected %0d actual %0d", $time, x.tv, a.tv); errs++;
          end
          if (x.rl != a.rl) begin
            $display("%0t: result_last expected %0d actual %0d", $time, x.rl, a.rl); errs++;
          end
        end
      end
      if (in_valid && in_ready) begin
        n_in++;
        model_item('{cmd, key_byte, byte_present, key_last, lookup_id});
      end
    end
  end

  // sender: bursts with gaps
  always @(posedge clk) begin : drv
    item_t it;
    int gap, burst;
    if (rst) begin
      in_valid <= 1'b0;
      gap = 0;
      burst = 0;
    end else if (!in_valid || in_ready) begin
      if (gap > 0 || pend_items.size() == 0) begin
        in_valid <= 1'b0;
        if (gap > 0) gap--;
      end else begin
        it = pend_items.pop_front();
        in_valid <= 1'b1;
        cmd <= it.cmd;
        key_byte <= it.kb;
        byte_present <= it.pres;
        key_last <= it.last;
        lookup_id <= it.lid;
        if (burst <= 1) begin
          burst = $urandom_range(1, 40);
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst--;
        end
      end
    end
  end

  // receiver: stall pattern picked at random from three modes, plus one long hold-off
  always @(posedge clk) begin : rcv
    int hold_cnt, mode, mcnt;
    bit hold_done;
    if (rst) begin
      out_ready <= 1'b0;
      hold_cnt = 0;
      hold_done = 0;
      mode = 0;
      mcnt = 0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done = 1;
      hold_cnt = 400;
      out_ready <= 1'b0;
    end else begin
      if (mcnt == 0) begin
        mode = $urandom_range(0, 2);
        mcnt = 64;
      end
      mcnt--;
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // stimulus
  logic [7:0] kb [70];
  logic [7:0] lib_b [128][MAXK];
  int lib_len [128];
  int lib_n = 0;

  function automatic void add(input logic [1:0] c, input logic [7:0] b, input logic p,
                              input logic l, input logic [9:0] id);
    queue_item(item_t'{c, b, p, l, id});
  endfunction

  function automatic void add_text(input logic [9:0] id);
    add(sih_pkg::CMD_TEXT, 8'($urandom), 1'($urandom), 1'($urandom), id);
  endfunction

  // key from kb[0..n-1]; noisy keys carry ignored items and text requests inside
  function automatic void send_key(input logic [1:0] c, input int n, input bit noisy);
    bit tail;
    tail = (n > 0) && noisy && ($urandom_range(0, 1) == 0);
    if (n == 0 || tail) begin
      for (int i = 0; i < n; i++) add(c, kb[i], 1'b1, 1'b0, 10'($urandom));
      add(c, 8'($urandom), 1'b0, 1'b1, 10'($urandom));
      return;
    end
    for (int i = 0; i < n; i++) begin
      if (noisy && $urandom_range(0, 4) == 0) add(c, 8'($urandom), 1'b0, 1'b0, 10'($urandom));
      if (noisy && $urandom_range(0, 6) == 0) add_text(10'($urandom_range(0, 40)));
      add(c, kb[i], 1'b1, i == n - 1, 10'($urandom));
    end
  endfunction

  function automatic void rand_key(input int n);
    for (int i = 0; i < n; i++) kb[i] = 8'($urandom);
  endfunction

  // wait until every item is taken and every result has come back
  task automatic drain();
    @(negedge clk);
    while (pend_items.size() != 0 || in_valid || exp_results.size() != 0) @(negedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_limit(input logic [10:0] v);
    @(posedge clk);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_part(input int count);
    int added, r, n, k;
    logic [1:0] c;
    added = 0;
    while (added < count) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        add_text(($urandom_range(0, 5) == 0) ? 10'($urandom) : 10'($urandom_range(0, 40)));
        added++;
      end else if (r < 14) begin
        add(CMD_NOP, 8'($urandom), 1'($urandom), 1'($urandom), 10'($urandom));
      end else begin
        c = ($urandom_range(0, 9) < 7) ? sih_pkg::CMD_INTERN : sih_pkg::CMD_CONTAINS;
        if (lib_n > 0 && $urandom_range(0, 99) < 45) begin
          k = $urandom_range(0, lib_n - 1);
          n = lib_len[k];
          for (int i = 0; i < n; i++) kb[i] = lib_b[k][i];
        end else begin
          r = $urandom_range(0, 99);
          n = (r < 75) ? $urandom_range(0, 6) : (r < 90) ? $urandom_range(7, 64)
                                                          : $urandom_range(65, 68);
          rand_key(n);
          if (n <= MAXK && lib_n < 128) begin
            for (int i = 0; i < n; i++) lib_b[lib_n][i] = kb[i];
            lib_len[lib_n] = n;
            lib_n++;
          end
        end
        send_key(c, n, $urandom_range(0, 4) == 0);
        added += (n == 0) ? 1 : n;
      end
    end
    drain();
  endtask

  initial begin : main
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: limit of one symbol, empty key, bad ids
    write_limit(11'd1);
    send_key(sih_pkg::CMD_INTERN, 0, 0);
    kb[0] = 8'h41;
    send_key(sih_pkg::CMD_INTERN, 1, 0);
    send_key(sih_pkg::CMD_CONTAINS, 0, 0);
    add_text(10'd0);
    add_text(10'd5);
    add_text(10'd1023);
    add(CMD_NOP, 8'hFF, 1'b1, 1'b1, 10'h3FF);
    drain();

    // directed: widest limit, extreme bytes, longest and overlong keys
    write_limit(11'd1024);
    kb[0] = 8'h00; kb[1] = 8'hFF;
    send_key(sih_pkg::CMD_INTERN, 2, 0);
    send_key(sih_pkg::CMD_CONTAINS, 2, 0);
    send_key(sih_pkg::CMD_INTERN, 2, 0);
    rand_key(64);
    send_key(sih_pkg::CMD_INTERN, 64, 0);
    rand_key(65);
    send_key(sih_pkg::CMD_INTERN, 65, 0);
    rand_key(70);
    send_key(sih_pkg::CMD_CONTAINS, 70, 0);
    add(sih_pkg::CMD_INTERN, 8'h11, 1'b1, 1'b0, 10'd0);
    add(sih_pkg::CMD_INTERN, 8'h22, 1'b0, 1'b0, 10'd0);
    add_text(10'd1);
    add(sih_pkg::CMD_INTERN, 8'h33, 1'b1, 1'b1, 10'd0);
    drain();

    // long receiver hold-off while text transactions pile up
    hold_req = 1;
    for (int i = 0; i < 4; i++) add_text(10'd2);
    rand_key(10);
    send_key(sih_pkg::CMD_INTERN, 10, 1);
    drain();

    random_part(50);
    write_limit(11'd6);
    random_part(40);
    write_limit(11'(sih_pkg::LIMIT_RESET));
    random_part(40);

    rand_key(3);
    send_key(sih_pkg::CMD_CONTAINS, 3, 0);
    send_key(sih_pkg::CMD_INTERN, 3, 0);
    add_text(10'd1023);
    drain();
    repeat (100) @(posedge clk);

    $display("Covered %0d input and %0d result transactions, %0d symbols, %0d pool bytes.",
             n_in, n_out, sym_cnt, pool_fill);
    if (exp_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, exp_results.size());
      errs++;
    end
    if (errs == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire
